### rtl/ipc_pkg.sv
package ipc_pkg;

    // largest supported n; the working table holds entries 0..MAX_N
    localparam int MAX_N   = 64;
    localparam int DEPTH   = MAX_N + 1;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int FIELD_W = 7;
    localparam int CNT_W   = 21;
    localparam int S_DATA_W = ((2 * FIELD_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((CNT_W + 7) / 8) * 8;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;   // capture n and m, start the clear sweep at entry zero
        logic clr;    // write one entry of the clear sweep
        logic rd;     // issue one table update (read j and j-k)
        logic done;   // move the finished count to the output register
    } cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic in_zero;   // input word gives a zero count right away
        logic j_at_n;    // entry counter sits at n
        logic k_at_m;    // part counter sits at the clamped bound
        logic out_free;  // output register can take a new word
    } sts_t;

endpackage

### rtl/ipc_ctrl.sv
module ipc_ctrl
    import ipc_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CLEAR = 3'd1;
    localparam logic [2:0] ST_RUN   = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = sts.in_zero ? ST_DONE : ST_CLEAR;
                end
            end
            ST_CLEAR: begin
                cmd.clr = 1'b1;
                if (sts.j_at_n) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                cmd.rd = 1'b1;
                if (sts.j_at_n && sts.k_at_m) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // last update is written back in this cycle
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (sts.out_free) begin
                    cmd.done   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/ipc_dpath.sv
module ipc_dpath
    import ipc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [FIELD_W-1:0] number,
    input  logic [FIELD_W-1:0] largest_part,
    input  cmd_t               cmd,
    output sts_t               sts,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [CNT_W-1:0]   out_count
);

    logic [CNT_W-1:0] mem [0:DEPTH-1];

    logic [IDX_W-1:0] n_reg;
    logic [IDX_W-1:0] m_reg;
    logic [IDX_W-1:0] j_reg;
    logic [IDX_W-1:0] k_reg;
    logic [IDX_W-1:0] wr_idx_reg;
    logic             wr_valid_reg;
    logic [CNT_W-1:0] rd_a_reg;
    logic [CNT_W-1:0] rd_b_reg;
    logic [CNT_W-1:0] count_reg;
    logic             out_valid_reg;
    logic [CNT_W-1:0] out_count_reg;

    logic [FIELD_W-1:0] m_eff;
    logic [IDX_W-1:0]   addr_a;
    logic [IDX_W-1:0]   addr_b;
    logic [CNT_W:0]     sum_full;
    logic [CNT_W-1:0]   sum;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [CNT_W-1:0]   wr_data;

    assign m_eff    = (largest_part > number) ? number : largest_part;
    assign addr_a   = j_reg;
    assign addr_b   = j_reg - k_reg;
    assign sum_full = {1'b0, rd_a_reg} + {1'b0, rd_b_reg};
    assign sum      = sum_full[CNT_W-1:0];

    // one write port shared by the clear sweep and the update stage
    assign wr_en   = cmd.clr || wr_valid_reg;
    assign wr_addr = cmd.clr ? j_reg : wr_idx_reg;
    assign wr_data = cmd.clr ? ((j_reg == '0) ? CNT_W'(1) : '0) : sum;

    assign sts.in_zero  = (number == '0) || (largest_part == '0)
                        || (number > FIELD_W'(MAX_N));
    assign sts.j_at_n   = (j_reg == n_reg);
    assign sts.k_at_m   = (k_reg == m_reg);
    assign sts.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_count = out_count_reg;

    // table memory, read ports bypass the write of the same edge
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd) begin
            rd_a_reg <= (wr_en && (wr_addr == addr_a)) ? wr_data : mem[addr_a];
            rd_b_reg <= (wr_en && (wr_addr == addr_b)) ? wr_data : mem[addr_b];
        end
    end

    // counters and update stage
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            n_reg     <= IDX_W'(number);
            m_reg     <= IDX_W'(m_eff);
            j_reg     <= '0;
            k_reg     <= IDX_W'(1);
            count_reg <= '0;
        end else if (cmd.clr) begin
            // sweep ends with j at the first entry of the first pass
            j_reg <= sts.j_at_n ? IDX_W'(1) : j_reg + IDX_W'(1);
        end else if (cmd.rd) begin
            wr_idx_reg <= j_reg;
            if (sts.j_at_n) begin
                k_reg <= k_reg + IDX_W'(1);
                j_reg <= k_reg + IDX_W'(1);
            end else begin
                j_reg <= j_reg + IDX_W'(1);
            end
        end
        if (wr_valid_reg) begin
            count_reg <= sum;
        end
        if (cmd.done) begin
            out_count_reg <= count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            wr_valid_reg <= cmd.rd;
            if (cmd.done) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_port_share: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.clr && wr_valid_reg))
        else $error("clear sweep collides with table update");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.done |-> (!out_valid_reg || out_ready))
        else $error("pending result overwritten");

    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd |-> (k_reg != '0 && k_reg <= m_reg && j_reg >= k_reg && j_reg <= n_reg))
        else $error("table update index out of range");

    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.rd && sts.j_at_n && sts.k_at_m) |=> (wr_valid_reg && !cmd.rd))
        else $error("last update not followed by drain");
`endif

endmodule

### rtl/integer_partition_count_unit.sv
// channel | dir | handshake         | data
// s_      | in  | s_tvalid/s_tready | s_tdata: number, largest_part
// m_      | out | m_tvalid/m_tready | m_tdata: count
//
// a word runs load, a clear sweep of 0..n, U = sum over k=1..min(m,n) of (n-k+1) table
// updates (one per cycle, single adder and write port; 2080 at n=m=64), drain, hand-off
// zero n, zero m or n above 64 skip the table and finish with a count of 0
// aresetn is synchronous, active low; the table itself is never cleared by reset
// a finished count waits in the output register while m_tready is low; the next
// input word is taken once the unit is back in idle
module integer_partition_count_unit
    import ipc_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // [6:0] number, [13:7] largest_part, rest zero
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata    // [20:0] count, rest zero
);

    cmd_t             cmd;
    sts_t             sts;
    logic [CNT_W-1:0] count;

    // sequencer: idle, clear sweep, update run, drain, hand-off
    ipc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // table memory, counters, adder and output register
    ipc_dpath u_dpath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .number       (s_tdata[FIELD_W-1:0]),
        .largest_part (s_tdata[2*FIELD_W-1:FIELD_W]),
        .cmd          (cmd),
        .sts          (sts),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_count    (count)
    );

    // pad the count up to whole bytes
    assign m_tdata = M_DATA_W'(count);

endmodule
